>>> hw/rtl/fcpm_pkg.sv
// ----------------------------------------------------------------------------
// fcpm_pkg: shared types, constants and color functions
// Holds the mode and register codes, the end colors and the base ramp used
// by the false color palette mapper.
// ----------------------------------------------------------------------------
package fcpm_pkg;

  // Color mode codes.
  localparam logic [2:0] MODE_BLUE_RED   = 3'd0;
  localparam logic [2:0] MODE_RED_BLUE   = 3'd1;
  localparam logic [2:0] MODE_GREY       = 3'd2;
  localparam logic [2:0] MODE_BANDED     = 3'd3;
  localparam logic [2:0] MODE_REV_GREY   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_COLOR_MODE    = 1'b0;
  localparam logic CFG_CONTOUR_COUNT = 1'b1;

  // Reset values.
  localparam logic [2:0] COLOR_MODE_RESET    = MODE_BLUE_RED;
  localparam logic [8:0] CONTOUR_COUNT_RESET = 9'd16;

  // Reciprocal of the band count, ceil(2^RECIP_SHIFT / n), exact for 16-bit dividends.
  localparam int         RECIP_SHIFT = 25;
  localparam int         RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1) << (RECIP_SHIFT - 4);

  // End colors.
  localparam logic [7:0] END_LOW_R  = 8'd39;
  localparam logic [7:0] END_LOW_G  = 8'd25;
  localparam logic [7:0] END_LOW_B  = 8'd201;
  localparam logic [7:0] END_HIGH_R = 8'd255;
  localparam logic [7:0] END_HIGH_G = 8'd25;
  localparam logic [7:0] END_HIGH_B = 8'd171;
  localparam logic [5:0] SEG_MAX    = 6'd63;
  localparam logic [7:0] FULL       = 8'd255;

  typedef struct packed {
    logic [2:0]         color_mode;
    logic [8:0]         band_count;   // clamped to 1..256
    logic [RECIP_W-1:0] recip;
  } fcpm_cfg_t;

  function automatic logic [31:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    pack_rgb = {r, g, b, FULL};
  endfunction

  function automatic logic [31:0] ramp(input logic [7:0] k);
    logic [7:0] up;
    logic [7:0] dn;
    up = {k[5:0], 2'b00};
    dn = {SEG_MAX - k[5:0], 2'b00};
    case (k[7:6])
      2'd0:    ramp = pack_rgb(8'd0, up, FULL);
      2'd1:    ramp = pack_rgb(8'd0, FULL, dn);
      2'd2:    ramp = pack_rgb(up, FULL, 8'd0);
      default: ramp = pack_rgb(FULL, dn, 8'd0);
    endcase
  endfunction

  // Ramp laid over levels 1..254 with fixed colors at both ends.
  function automatic logic [31:0] blue_red(input logic [7:0] lv);
    if (lv == 8'd0) begin
      blue_red = pack_rgb(END_LOW_R, END_LOW_G, END_LOW_B);
    end else if (lv == 8'd255) begin
      blue_red = pack_rgb(END_HIGH_R, END_HIGH_G, END_HIGH_B);
    end else if (lv <= 8'd126) begin
      blue_red = ramp(lv - 8'd1);
    end else begin
      blue_red = ramp(lv + 8'd1);
    end
  endfunction

endpackage

>>> hw/rtl/false_color_palette_map_core.sv
// ----------------------------------------------------------------------------
// false_color_palette_map_core: false color palette mapper
// Turns an 8-bit level into a packed RGBA word in one of five color modes.
// ----------------------------------------------------------------------------
// Usage:
// Levels enter on the slave stream (s_tvalid, s_tready, s_tdata) and packed
// colors leave on the master stream (m_tvalid, m_tready, m_tdata). A word is
// taken whenever tvalid and tready are both high on a rising clock edge.
// The pipeline holds three register stages: a level is registered in stage 1,
// then stage 2, and its color in the output register that drives m_tdata. One
// level can be taken every cycle while m_tready stays high and no divide runs.
// The two band multiplies each have a stage of their own.
// When the receiver drops m_tready, the stages hold their words and empty
// stages keep filling, so s_tready falls only once the whole pipeline is full.
// Registers are written on the cfg channel: index 0 is the color mode, index
// 1 the band count. A write of the band count starts a serial divider that
// forms its reciprocal; s_tready and cfg_ready are low while it runs.
// The synchronous reset rst empties the pipeline and loads mode 0 and a band
// count of 16, whose reciprocal is loaded directly, so no divide follows reset.
// ----------------------------------------------------------------------------
module false_color_palette_map_core
  import fcpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Level stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] level
  // Color stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] packed_color
  // Register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [2:0]         color_mode;
  logic [8:0]         contour_count;
  logic [8:0]         band_count;
  logic [RECIP_W-1:0] recip;
  logic               recip_busy;
  logic               cfg_wr;
  logic               recip_start;
  logic               pipe_ready;
  fcpm_cfg_t          pipe_cfg;

  assign cfg_ready   = !recip_busy;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign recip_start = cfg_wr && (cfg_index == CFG_CONTOUR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode    <= COLOR_MODE_RESET;
      contour_count <= CONTOUR_COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:    color_mode    <= cfg_data[2:0];
        CFG_CONTOUR_COUNT: contour_count <= cfg_data;
        default:           color_mode    <= color_mode;
      endcase
    end
  end

  // A count of zero behaves as one, and anything above 256 as 256.
  always_comb begin
    if (contour_count == 9'd0) begin
      band_count = 9'd1;
    end else if (contour_count > 9'd256) begin
      band_count = 9'd256;
    end else begin
      band_count = contour_count;
    end
  end

  // The divider reads the updated count from the cycle after the write on.
  fcpm_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (recip_start),
    .divisor (band_count),
    .busy    (recip_busy),
    .recip   (recip)
  );

  assign pipe_cfg = '{color_mode: color_mode, band_count: band_count, recip: recip};

  // Levels are held off while the reciprocal is being formed.
  assign s_tready = pipe_ready && !recip_busy;

  fcpm_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (pipe_cfg),
    .in_valid  (s_tvalid && !recip_busy),
    .in_ready  (pipe_ready),
    .in_level  (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_color (m_tdata)
  );

endmodule

>>> hw/rtl/fcpm_recip.sv
// ----------------------------------------------------------------------------
// fcpm_recip: band count reciprocal
// Serial restoring divider that forms ceil(2^25 / n) one quotient bit per
// cycle after each write of the band count.
// ----------------------------------------------------------------------------
module fcpm_recip
  import fcpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [8:0]         divisor,
  output logic               busy,
  output logic [RECIP_W-1:0] recip
);

  localparam logic [4:0] LAST_STEP = 5'(RECIP_SHIFT - 1);

  logic [8:0]             rem;
  logic [RECIP_SHIFT-2:0] quot;
  logic [4:0]             step;
  logic [9:0]             rem_sh;
  logic                   qbit;
  logic [9:0]             rem_sub;

  // The dividend is 2^25 - 1, so every shifted-in bit is one.
  assign rem_sh  = {rem, 1'b1};
  assign qbit    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      recip <= RECIP_RESET;
      step  <= '0;
      rem   <= '0;
      quot  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? rem_sub[8:0] : rem_sh[8:0];
      quot <= {quot[RECIP_SHIFT-3:0], qbit};
      step <= step + 5'd1;
      if (step == LAST_STEP) begin
        busy  <= 1'b0;
        recip <= {1'b0, quot, qbit} + RECIP_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/fcpm_pipe.sv
// ----------------------------------------------------------------------------
// fcpm_pipe: three-stage color pipeline
// Forms the band index with two registered multiplies and selects the final
// color in the output stage.
// ----------------------------------------------------------------------------
module fcpm_pipe
  import fcpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fcpm_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [31:0] out_color
);

  logic        v1, v2;
  logic        en1, en2, en3;
  logic [7:0]  lvl1, lvl2;
  logic [15:0] t1;
  logic [7:0]  prod_hi2;
  logic        lo2, hi2;

  logic [15:0] t_dec;
  logic [7:0]  s_band;
  logic [16:0] u_rest;
  logic [33:0] prod;
  logic [7:0]  j_sum;
  logic [7:0]  j_band;
  logic [31:0] color_next;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 2 arithmetic: band index and the end tests.
  assign t_dec  = t1 - 16'd1;
  assign s_band = (lvl1 == 8'd0) ? 8'd0 : t_dec[15:8];
  assign u_rest = {cfg.band_count, 8'd0} - {8'd0, cfg.band_count} - {1'b0, t1};
  assign prod   = {26'd0, s_band} * {8'd0, cfg.recip};

  // Stage 3: ramp index for banded mode.
  assign j_sum  = prod_hi2 + cfg.recip[RECIP_W-1:RECIP_W-8];
  assign j_band = hi2 ? 8'd255 : (lo2 ? 8'd0 : j_sum);

  always_comb begin
    case (cfg.color_mode)
      MODE_RED_BLUE: color_next = blue_red(~lvl2);
      MODE_GREY:     color_next = pack_rgb(lvl2, lvl2, lvl2);
      MODE_BANDED:   color_next = ramp(j_band);
      MODE_REV_GREY: color_next = pack_rgb(~lvl2, ~lvl2, ~lvl2);
      default:       color_next = blue_red(lvl2);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lvl1 <= in_level;
      t1   <= 16'({8'd0, in_level} * {7'd0, cfg.band_count});
    end
    if (en2) begin
      lvl2     <= lvl1;
      prod_hi2 <= prod[24:17];
      lo2      <= (t1[15:8] == 8'd0);
      hi2      <= (u_rest[16:8] == 9'd0);
    end
    if (en3) begin
      out_color <= color_next;
    end
  end

endmodule

>>> sim/false_color_palette_map_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// false_color_palette_map_core_test: self-checking bench for the palette mapper
// Sends levels through the core under every color mode and a spread of band
// counts. A local color predictor turns each accepted level into the packed
// RGBA word it should produce, and each word leaving the core is compared
// against the oldest expected color.
// ----------------------------------------------------------------------------
module false_color_palette_map_core_test;
  import fcpm_pkg::*;

  // Mode codes that the core does not define; they must fall back to blue-red.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  // Fixed colors at both ends of the stretched ramp.
  localparam logic [7:0] LOW_END_R  = 8'd39;
  localparam logic [7:0] LOW_END_G  = 8'd25;
  localparam logic [7:0] LOW_END_B  = 8'd201;
  localparam logic [7:0] HIGH_END_R = 8'd255;
  localparam logic [7:0] HIGH_END_G = 8'd25;
  localparam logic [7:0] HIGH_END_B = 8'd171;

  localparam int N_DIRECTED  = 25;
  localparam int PIPE_SLACK  = 8;      // cycles allowed past the last color
  localparam int HOLD_CYCLES = 300;    // long back-pressure stretch
  localparam int TIMEOUT_NS  = 1_000_000;

  typedef struct {
    logic [7:0]  level;
    logic [2:0]  mode;
    logic [31:0] color;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] level
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] packed_color
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_COLOR_MODE;
  logic [8:0]  cfg_data = '0;

  // Shadow of the core's registers, used by the predictor.
  logic [2:0]  cur_mode  = COLOR_MODE_RESET;
  logic [8:0]  cur_bands = CONTOUR_COUNT_RESET;

  logic [7:0]  level_queue[$];   // levels waiting to be sent
  shade_t      color_queue[$];   // colors the core still owes us

  logic        steady = 1'b0;    // when set, neither side inserts idle cycles
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  int          mismatches = 0;
  int          levels_taken = 0;
  int          colors_seen = 0;
  int          settings_used = 0;

  logic [7:0]  dir_levels[N_DIRECTED];
  logic [2:0]  dir_modes[N_DIRECTED];

  false_color_palette_map_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rgba(input int unsigned r, input int unsigned g,
                                       input int unsigned b);
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r8 = r[7:0];
    g8 = g[7:0];
    b8 = b[7:0];
    return {r8, g8, b8, 8'hFF};
  endfunction

  // Base jet ramp: four 64-step segments, blue-cyan-green-yellow-red.
  function automatic logic [31:0] ramp_color(input logic [7:0] k);
    int unsigned pos;
    int unsigned rise;
    int unsigned fall;
    pos  = k[5:0];
    rise = 4 * pos;
    fall = 4 * (63 - pos);
    case (k[7:6])
      2'd0:    return rgba(0, rise, 255);
      2'd1:    return rgba(0, 255, fall);
      2'd2:    return rgba(rise, 255, 0);
      default: return rgba(255, fall, 0);
    endcase
  endfunction

  // Ramp stretched over levels 1..254; entries 126 and 127 are skipped.
  function automatic logic [31:0] ramp_with_ends(input logic [7:0] lv);
    if (lv == 8'd0) begin
      return {LOW_END_R, LOW_END_G, LOW_END_B, 8'hFF};
    end else if (lv == 8'd255) begin
      return {HIGH_END_R, HIGH_END_G, HIGH_END_B, 8'hFF};
    end else if (lv <= 8'd126) begin
      return ramp_color(lv - 8'd1);
    end else begin
      return ramp_color(lv + 8'd1);
    end
  endfunction

  // Contour bands: band index from level*count, then the band's ramp entry.
  // The lowest band is pinned to blue and the highest to red.
  function automatic logic [31:0] contour_color(input logic [7:0] lv,
                                                input logic [8:0] bands);
    int unsigned n;
    int unsigned l;
    int unsigned prod;
    int unsigned band;
    int unsigned idx;
    n = bands;
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    l    = lv;
    prod = l * n;
    band = (l == 0) ? 0 : (prod - 1) / 256;
    idx  = (256 * band) / n + 128 / n;
    if (prod < 256) idx = 0;
    if ((255 - l) * n < 256) idx = 255;
    return ramp_color(idx[7:0]);
  endfunction

  function automatic logic [31:0] predict_color(input logic [7:0] lv, input logic [2:0] mode,
                                                input logic [8:0] bands);
    case (mode)
      MODE_RED_BLUE: return ramp_with_ends(8'd255 - lv);
      MODE_GREY:     return rgba(lv, lv, lv);
      MODE_BANDED:   return contour_color(lv, bands);
      MODE_REV_GREY: return rgba(255 - lv, 255 - lv, 255 - lv);
      default:       return ramp_with_ends(lv);
    endcase
  endfunction

  // ------------------------------------------------------------------ driver

  // A new level is presented once the previous word has been taken; about
  // one cycle in seven is left idle unless the steady stretch is on.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (level_queue.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= level_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Random stalls, plus one long hold-off on request so the pipeline fills
  // and the core has to push back on its level input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      m_tready    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asks;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    shade_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want.level = s_tdata;
        want.mode  = cur_mode;
        want.color = predict_color(s_tdata, cur_mode, cur_bands);
        color_queue.push_back(want);
        levels_taken <= levels_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        colors_seen <= colors_seen + 1;
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected color word, expected none, got %08h", $time, m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = color_queue.pop_front();
          if (m_tdata !== want.color) begin
            $display("%0t: packed_color mismatch, level %0d mode %0d: expected %08h, got %08h",
                     $time, want.level, want.mode, want.color, m_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- sequencing

  // Waits until every queued level has gone in and every color has come out.
  task automatic settle();
    @(negedge clk);
    while (level_queue.size() != 0 || s_tvalid || color_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // Register write; the core holds cfg_ready low while the divider runs.
  task automatic write_reg(input logic idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_COLOR_MODE) begin
      cur_mode <= val[2:0];
    end else begin
      cur_bands <= val;
    end
  endtask

  // One register setting followed by a batch of random levels, a fifth of
  // them picked from the ends of the range and the skipped ramp entries.
  task automatic run_phase(input logic [2:0] mode, input logic [8:0] bands, input int count,
                           input logic no_gaps, input logic long_hold);
    logic [7:0] lv;
    settle();
    write_reg(CFG_COLOR_MODE, {6'd0, mode});
    write_reg(CFG_CONTOUR_COUNT, bands);
    settings_used++;
    @(negedge clk);
    steady <= no_gaps;
    if (long_hold) hold_asks <= hold_asks + 1;
    repeat (count) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(5))
          0:       lv = 8'd0;
          1:       lv = 8'd1;
          2:       lv = 8'd126;
          3:       lv = 8'd127;
          4:       lv = 8'd254;
          default: lv = 8'd255;
        endcase
      end else begin
        lv = 8'($urandom_range(255));
      end
      level_queue.push_back(lv);
    end
    settle();
    steady <= 1'b0;
  endtask

  initial begin
    // Directed levels: the ramp ends in each mode and the skipped entries in the
    // blue-red modes, then band edges at the reset band count of 16.
    dir_levels = '{8'd0, 8'd1, 8'd64, 8'd126, 8'd127, 8'd128, 8'd254, 8'd255,
                   8'd0, 8'd127, 8'd128, 8'd255,
                   8'd0, 8'd170, 8'd255,
                   8'd0, 8'd255,
                   8'd0, 8'd1, 8'd16, 8'd17, 8'd128, 8'd239, 8'd240, 8'd255};
    dir_modes  = '{MODE_BLUE_RED, MODE_BLUE_RED, MODE_BLUE_RED, MODE_BLUE_RED,
                   MODE_BLUE_RED, MODE_BLUE_RED, MODE_BLUE_RED, MODE_BLUE_RED,
                   MODE_RED_BLUE, MODE_RED_BLUE, MODE_RED_BLUE, MODE_RED_BLUE,
                   MODE_GREY, MODE_GREY, MODE_GREY,
                   MODE_REV_GREY, MODE_REV_GREY,
                   MODE_BANDED, MODE_BANDED, MODE_BANDED, MODE_BANDED,
                   MODE_BANDED, MODE_BANDED, MODE_BANDED, MODE_BANDED};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first block runs on the reset band count; only the color mode is written.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_modes[i] != cur_mode) begin
        settle();
        write_reg(CFG_COLOR_MODE, {6'd0, dir_modes[i]});
        @(negedge clk);
      end
      level_queue.push_back(dir_levels[i]);
    end

    // Random part. Band counts of 0 and above 256 must clamp, and the
    // undefined mode codes must behave as blue-red.
    run_phase(MODE_BLUE_RED, 9'd1,   25, 1'b0, 1'b0);
    run_phase(MODE_RED_BLUE, 9'd200, 25, 1'b0, 1'b0);
    run_phase(MODE_GREY,     9'd77,  25, 1'b0, 1'b0);
    run_phase(MODE_REV_GREY, 9'd300, 25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd1,   25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd256, 25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd0,   25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd257, 25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd511, 25, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'($urandom_range(2, 255)), 60, 1'b1, 1'b0);
    run_phase(MODE_SPARE_5,  9'($urandom_range(511)), 15, 1'b0, 1'b0);
    run_phase(MODE_SPARE_6,  9'($urandom_range(511)), 15, 1'b0, 1'b0);
    run_phase(MODE_SPARE_7,  9'($urandom_range(511)), 15, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'd3,   40, 1'b0, 1'b1);
    run_phase(MODE_BANDED,   9'd255, 25, 1'b0, 1'b0);
    run_phase(MODE_BLUE_RED, 9'd16,  20, 1'b0, 1'b0);
    run_phase(MODE_BANDED,   9'($urandom_range(2, 255)), 20, 1'b0, 1'b0);

    $display("Covered %0d levels and %0d colors over all eight mode codes and %0d settings,",
             levels_taken, colors_seen, settings_used);
    $display("band counts 0, 1, 3, 255, 256, 257 and 511, a long output stall and a gap-free run.");
    if (mismatches == 0 && color_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d colors outstanding.", color_queue.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fcpm_pkg.sv
hw/rtl/fcpm_recip.sv
hw/rtl/fcpm_pipe.sv
hw/rtl/false_color_palette_map_core.sv
sim/false_color_palette_map_core_test.sv
